// ----- design/pfba_pkg.sv -----
// Shared types and constants for the page frame bitmap allocator.
`default_nettype none

package pfba_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WORD_SHIFT = 5;
  localparam int unsigned ADDR_W     = 22;
  localparam int unsigned LEN_W      = 23;
  localparam int unsigned WIDE_W     = 40;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] result_address;
    logic [LEN_W-1:0]  granted_bytes;
    logic [LEN_W-1:0]  released_bytes;
  } pfba_result_t;

endpackage

`default_nettype wire

// ----- design/pfba_bitmap_mem.sv -----
// Single-port-write, registered-read memory holding the frame used bitmap.
`default_nettype none

module pfba_bitmap_mem
  import pfba_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/pfba_ctrl.sv -----
// Sequencer that scans, checks, marks and releases runs in the bitmap memory.
`default_nettype none

module pfba_ctrl
  import pfba_pkg::*;
#(
  parameter int unsigned FRAME_COUNT = 1024,
  parameter int unsigned PAGE_BYTES  = 4096,
  parameter int unsigned WORDS       = 32,
  parameter int unsigned WA_W        = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_op,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic [LEN_W-1:0]  in_length_bytes,
  output logic                   in_ready,
  output logic                   res_valid,
  output pfba_result_t           res,
  input  wire logic              res_ready,
  output logic                   mem_we,
  output logic      [WA_W-1:0]   mem_waddr,
  output logic      [WORD_W-1:0] mem_wdata,
  output logic                   mem_re,
  output logic      [WA_W-1:0]   mem_raddr,
  input  wire logic [WORD_W-1:0] mem_rdata
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned FI_W  = $clog2(FRAME_COUNT + 1);
  localparam int unsigned CNT_W = LEN_W + 1 - PAGE_SHIFT;
  localparam int unsigned POS_W = ((FI_W > CNT_W) ? FI_W : CNT_W) + 1;
  localparam logic [POS_W-1:0] FC_POS  = POS_W'(FRAME_COUNT);
  localparam logic [WA_W-1:0]  LAST_WA = WA_W'(WORDS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SRCH_RD, ST_SRCH_EV, ST_CHK_RD, ST_CHK_EV,
    ST_MARK_RD, ST_MARK_WR, ST_REL_RD, ST_REL_WR, ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [WA_W-1:0]  clr_r, clr_nxt;
  logic             op_r, op_nxt;
  logic             fail_r, fail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [POS_W-1:0] cur_r, cur_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [FI_W-1:0]  freed_r, freed_nxt;

  logic [POS_W-1:0]  first_c, count_c, rel_end_c;
  logic [LEN_W:0]    round_c;
  logic [POS_W-1:0]  base_c, next_word_c, idx_c, sum_c;
  logic [WORD_W-1:0] win_c, avail_c, hit_c;
  logic [WORD_SHIFT-1:0] off_c;
  logic [WORD_SHIFT:0]   pop_c;
  logic [WIDE_W-1:0] addr_wide_c, gran_wide_c, rel_wide_c;

  function automatic logic [WORD_W-1:0] range_mask(input logic [POS_W-1:0] base,
                                                   input logic [POS_W-1:0] lo,
                                                   input logic [POS_W-1:0] hi);
    logic [WORD_W-1:0] m;
    logic [POS_W-1:0]  p;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      p = base + POS_W'(b);
      m[b] = (p >= lo) && (p < hi);
    end
    return m;
  endfunction

  assign round_c   = (LEN_W+1)'(in_length_bytes) + (LEN_W+1)'(PAGE_BYTES - 1);
  assign count_c   = POS_W'(round_c >> PAGE_SHIFT);
  assign first_c   = POS_W'(in_address >> PAGE_SHIFT);
  assign rel_end_c = ((first_c + count_c) > FC_POS) ? FC_POS : (first_c + count_c);

  assign base_c      = cur_r & ~POS_W'(WORD_W - 1);
  assign next_word_c = base_c + POS_W'(WORD_W);
  assign win_c       = range_mask(base_c, cur_r,
                                  (state_r == ST_SRCH_EV) ? FC_POS : end_r);
  assign avail_c     = ~mem_rdata & win_c;
  assign hit_c       = mem_rdata & win_c;
  assign idx_c       = base_c + POS_W'(off_c);
  assign sum_c       = idx_c + POS_W'(cnt_r);

  always_comb begin
    off_c = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail_c[b]) begin
        off_c = WORD_SHIFT'(b);
      end
    end
  end

  always_comb begin
    pop_c = '0;
    for (int b = 0; b < WORD_W; b++) begin
      pop_c = pop_c + (WORD_SHIFT+1)'(hit_c[b]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    fail_nxt  = fail_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    freed_nxt = freed_r;
    mem_we    = 1'b0;
    mem_waddr = WA_W'(cur_r >> WORD_SHIFT);
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = WA_W'(cur_r >> WORD_SHIFT);
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + WA_W'(1);
        if (clr_r == LAST_WA) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          fail_nxt  = 1'b0;
          cnt_nxt   = CNT_W'(count_c);
          cur_nxt   = first_c;
          idx_nxt   = first_c;
          freed_nxt = '0;
          if (in_op == OP_RESERVE) begin
            if (first_c >= FC_POS) begin
              fail_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SRCH_RD;
            end
          end else begin
            end_nxt   = rel_end_c;
            state_nxt = (first_c >= rel_end_c) ? ST_DONE : ST_REL_RD;
          end
        end
      end
      ST_SRCH_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_SRCH_EV;
      end
      ST_SRCH_EV: begin
        if (avail_c == '0) begin
          cur_nxt = next_word_c;
          if (next_word_c >= FC_POS) begin
            fail_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SRCH_RD;
          end
        end else if (sum_c > FC_POS) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_c;
          end_nxt = sum_c;
          if (cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else if (cnt_r == CNT_W'(1)) begin
            cur_nxt   = idx_c;
            state_nxt = ST_MARK_RD;
          end else begin
            cur_nxt   = idx_c + POS_W'(1);
            state_nxt = ST_CHK_RD;
          end
        end
      end
      ST_CHK_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_CHK_EV;
      end
      ST_CHK_EV: begin
        if (hit_c != '0) begin
          cur_nxt = end_r;
          if (end_r >= FC_POS) begin
            fail_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SRCH_RD;
          end
        end else if (next_word_c >= end_r) begin
          cur_nxt   = idx_r;
          state_nxt = ST_MARK_RD;
        end else begin
          cur_nxt   = next_word_c;
          state_nxt = ST_CHK_RD;
        end
      end
      ST_MARK_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | win_c;
        cur_nxt   = next_word_c;
        state_nxt = (next_word_c >= end_r) ? ST_DONE : ST_MARK_RD;
      end
      ST_REL_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_REL_WR;
      end
      ST_REL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & ~win_c;
        freed_nxt = freed_r + FI_W'(pop_c);
        cur_nxt   = next_word_c;
        state_nxt = (next_word_c >= end_r) ? ST_DONE : ST_REL_RD;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    op_r    <= op_nxt;
    fail_r  <= fail_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    cur_r   <= cur_nxt;
    end_r   <= end_nxt;
    freed_r <= freed_nxt;
  end

  assign addr_wide_c = WIDE_W'(idx_r) << PAGE_SHIFT;
  assign gran_wide_c = WIDE_W'(cnt_r) << PAGE_SHIFT;
  assign rel_wide_c  = WIDE_W'(freed_r) << PAGE_SHIFT;

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  always_comb begin
    res = '0;
    if (op_r == OP_RELEASE) begin
      res.released_bytes = rel_wide_c[LEN_W-1:0];
    end else if (fail_r) begin
      res.status = STATUS_NO_SPACE;
    end else begin
      res.status         = STATUS_DONE;
      res.result_address = addr_wide_c[ADDR_W-1:0];
      res.granted_bytes  = gran_wide_c[LEN_W-1:0];
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("bitmap read and write in the same cycle");

  a_read_then_use: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> !mem_re && (state_r == ST_SRCH_EV || state_r == ST_CHK_EV ||
                           state_r == ST_MARK_WR || state_r == ST_REL_WR))
    else $error("read data not consumed in the following cycle");

  a_mark_sets_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK_WR) |-> ((mem_wdata & mem_rdata) == mem_rdata))
    else $error("mark cleared a used frame");

  a_release_clears_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL_WR) |-> ((mem_wdata & ~mem_rdata) == '0))
    else $error("release set a frame");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == STATUS_NO_SPACE) |->
      (res.result_address == '0 && res.granted_bytes == '0 && res.released_bytes == '0))
    else $error("no-space result carries nonzero fields");

endmodule

`default_nettype wire

// ----- design/page_frame_bitmap_allocator.sv -----
// Top level of the first-fit page frame bitmap allocator.
//
// Input channel (in_valid / in_stall): in_op selects reserve or release,
// in_address is the hint or run start in bytes, in_length_bytes is rounded
// up to whole pages. Result channel (out_valid / out_stall): one transfer per
// input with status, reserved address, granted bytes and released bytes.
// Items are worked one at a time; a new item is taken once the sequencer is
// idle, even while the previous result still waits in the output register.
// The bitmap sits in a memory of 32-bit words with a registered read.
// Each word visited takes a read state and then an evaluate or write-back
// state: a reserve reads each word it searches, checks and marks, and a
// release each word of its run. Each item also passes the idle state that
// takes it and the done state that hands the result to the output register.
// A run that meets a used frame restarts the search at the end of that run.
// PAGE_BYTES must be a power of two; the block itself does not check it.
// After reset a clearing pass writes every word of the bitmap to zero while
// in_stall is held high.
// While out_stall is high the result holds and the sequencer waits in its
// done state once it has a further result.
`default_nettype none

module page_frame_bitmap_allocator
  import pfba_pkg::*;
#(
  parameter int unsigned FRAME_COUNT = 1024,
  parameter int unsigned PAGE_BYTES  = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_op,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic [LEN_W-1:0]  in_length_bytes,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_status,
  output logic      [ADDR_W-1:0] out_result_address,
  output logic      [LEN_W-1:0]  out_granted_bytes,
  output logic      [LEN_W-1:0]  out_released_bytes
);

  localparam int unsigned WORDS = (FRAME_COUNT + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic              eng_ready;
  logic              res_valid;
  logic              res_ready;
  pfba_result_t      res;
  logic              mem_we;
  logic [WA_W-1:0]   mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [WA_W-1:0]   mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic              out_valid_r, out_valid_nxt;
  pfba_result_t      out_res_r, out_res_nxt;

  pfba_ctrl #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BYTES  (PAGE_BYTES),
    .WORDS       (WORDS),
    .WA_W        (WA_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_op           (in_op),
    .in_address      (in_address),
    .in_length_bytes (in_length_bytes),
    .in_ready        (eng_ready),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  pfba_bitmap_mem #(
    .DEPTH (WORDS),
    .AW    (WA_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall  = !eng_ready;
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_result_address = out_res_r.result_address;
  assign out_granted_bytes  = out_res_r.granted_bytes;
  assign out_released_bytes = out_res_r.released_bytes;

endmodule

`default_nettype wire
